// File: design/mts_pkg.sv
// ---------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the minimum-tracking stack unit.
// ---------------------------------------------------------------------------
package mts_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W     = 7;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  localparam int OUT_FIELDS_W = 2 * DATA_W + DEPTH_W + STATUS_W;
  localparam int IN_TDATA_W   = ((DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Bit positions of the result fields in out_tdata.
  localparam int TOP_LSB    = 0;
  localparam int MIN_LSB    = TOP_LSB + DATA_W;
  localparam int DEPTH_LSB  = MIN_LSB + DATA_W;
  localparam int STATUS_LSB = DEPTH_LSB + DEPTH_W;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_t;

  // Shift command broadcast to every cell of one chain.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

// File: design/mts_cell.sv
// ---------------------------------------------------------------------------
// mts_cell
// One stack entry: takes the entry above on a push, the entry below on a pop.
// ---------------------------------------------------------------------------
module mts_cell
  import mts_pkg::*;
(
  input  logic              clk,
  input  shift_t            ctl,
  input  logic [DATA_W-1:0] from_above,
  input  logic [DATA_W-1:0] from_below,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.push) begin
      data_nxt = from_above;
    end else if (ctl.pop) begin
      data_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// File: design/mts_chain.sv
// ---------------------------------------------------------------------------
// mts_chain
// Row of stack cells with the top entry in cell 0.
// ---------------------------------------------------------------------------
module mts_chain
  import mts_pkg::*;
(
  input  logic              clk,
  input  shift_t            ctl,
  input  logic [DATA_W-1:0] push_data,
  output logic [DATA_W-1:0] top_o,
  output logic [DATA_W-1:0] next_o
);

  logic [DATA_W-1:0] cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] below;

    if (i == 0) begin : g_first
      assign above = push_data;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end

    // The bottom cell keeps its own value on a pop; it is then beyond the count.
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = cell_q[i];
    end else begin : g_inner
      assign below = cell_q[i+1];
    end

    mts_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .data_o     (cell_q[i])
    );
  end

  assign top_o  = cell_q[0];
  assign next_o = cell_q[1];

endmodule

// File: design/min_tracking_stack_unit.sv
// ---------------------------------------------------------------------------
// min_tracking_stack_unit
// Bounded stack of signed values that reports its minimum with every result.
//
//   Channel | Direction | Contents
//   in_     | slave     | tuser: operation; tdata: push_value
//   out_    | master    | tdata: top_value, min_value, stack_depth, status
//
// One transfer in gives one transfer out, registered and presented in the cycle after it is taken.
// A new item is taken every cycle while the output register is empty or
// being drained; each operation shifts both cell chains by at most one
// place.
// Reset clears both counts and the output valid; cell contents are not reset.
// A stalled output holds its result and back-pressures the input.
// ---------------------------------------------------------------------------
module min_tracking_stack_unit
  import mts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] push_value
  input  logic [OP_W-1:0]        in_tuser,   // [1:0] operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] top_value, [63:32] min_value,
                                             // [70:64] stack_depth, [72:71] status
);

  logic              accept;
  op_t               op;
  logic [DATA_W-1:0] push_val;

  logic [CNT_W-1:0]  vcount_r, vcount_nxt;
  logic [CNT_W-1:0]  mcount_r, mcount_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  shift_t            vctl, mctl;
  logic [DATA_W-1:0] vtop, vnext, mtop, mnext;
  logic [DATA_W-1:0] top_res, min_res;
  status_t           status;

  assign accept   = in_tvalid && in_tready;
  assign op       = op_t'(in_tuser);
  assign push_val = in_tdata[DATA_W-1:0];

  always_comb begin
    vctl   = '0;
    mctl   = '0;
    status = ST_OK;
    unique case (op)
      OP_PUSH: begin
        if (vcount_r < CNT_W'(STACK_DEPTH)) begin
          vctl.push = accept;
          // Equal values go on the minimum stack too, so duplicates pop cleanly.
          mctl.push = accept && ((mcount_r == '0) || ($signed(mtop) >= $signed(push_val)));
        end else begin
          status = ST_PUSH_FULL;
        end
      end
      OP_POP: begin
        if (vcount_r != '0) begin
          vctl.pop = accept;
          mctl.pop = accept && (mcount_r != '0) && (mtop == vtop);
        end else begin
          status = ST_POP_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  mts_chain u_value_chain (
    .clk       (clk),
    .ctl       (vctl),
    .push_data (push_val),
    .top_o     (vtop),
    .next_o    (vnext)
  );

  mts_chain u_minima_chain (
    .clk       (clk),
    .ctl       (mctl),
    .push_data (push_val),
    .top_o     (mtop),
    .next_o    (mnext)
  );

  always_comb begin
    vcount_nxt = vcount_r;
    mcount_nxt = mcount_r;
    if (vctl.push) begin
      vcount_nxt = vcount_r + CNT_W'(1);
    end else if (vctl.pop) begin
      vcount_nxt = vcount_r - CNT_W'(1);
    end
    if (mctl.push) begin
      mcount_nxt = mcount_r + CNT_W'(1);
    end else if (mctl.pop) begin
      mcount_nxt = mcount_r - CNT_W'(1);
    end
  end

  // Result fields reflect the state after this transfer's operation.
  always_comb begin
    top_res = '0;
    min_res = '0;
    if (vcount_nxt != '0) begin
      top_res = vctl.push ? push_val : (vctl.pop ? vnext : vtop);
      if (mcount_nxt != '0) begin
        min_res = mctl.push ? push_val : (mctl.pop ? mnext : mtop);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[TOP_LSB +: DATA_W]      = top_res;
      out_data_nxt[MIN_LSB +: DATA_W]      = min_res;
      out_data_nxt[DEPTH_LSB +: DEPTH_W]   = DEPTH_W'(vcount_nxt);
      out_data_nxt[STATUS_LSB +: STATUS_W] = status;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= '0;
      mcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vcount_r    <= vcount_nxt;
      mcount_r    <= mcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: design/mts_checker.sv
// ---------------------------------------------------------------------------
// mts_checker
// Port-level checks on the result channel of the minimum-tracking stack.
// ---------------------------------------------------------------------------
module mts_checker
  import mts_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [DATA_W-1:0]   top_f;
  logic [DATA_W-1:0]   min_f;
  logic [DEPTH_W-1:0]  depth_f;
  logic [STATUS_W-1:0] status_f;

  assign top_f    = out_tdata[TOP_LSB +: DATA_W];
  assign min_f    = out_tdata[MIN_LSB +: DATA_W];
  assign depth_f  = out_tdata[DEPTH_LSB +: DEPTH_W];
  assign status_f = out_tdata[STATUS_LSB +: STATUS_W];

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (depth_f == '0) |-> (top_f == '0) && (min_f == '0))
    else $error("empty stack reports nonzero top or minimum");

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status_f == ST_PUSH_FULL) |-> depth_f == DEPTH_W'(STACK_DEPTH))
    else $error("push rejected while stack not full");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status_f == ST_POP_EMPTY) |-> depth_f == '0)
    else $error("pop rejected while stack not empty");

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
